[hdl/pol_pkg.sv]
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types, sizes and helpers of the positional ordered list: element
// and index types, request and status codes, cell shift commands and the
// search probe that walks the cell row.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;

    // field widths of the request and response transactions
    localparam int REQ_W   = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int FPOS_W  = 7;
    localparam int LEN_W   = 7;

    // derived sizes
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic signed [ELEM_WIDTH-1:0] elem_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_GET    = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_PRIOR  = 3'd4,
        REQ_NEXT   = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_NOTFOUND = 3'd2,
        STAT_NOEDGE   = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    // shift command broadcast to every cell
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_DELETE
    } shift_op_t;

    typedef struct packed {
        shift_op_t op;
        idx_t      idx;
        elem_t     key;
    } shift_cmd_t;

    // search/read probe handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic  active;
        req_t  kind;
        idx_t  target;
        elem_t key;
        logic  found;
        idx_t  fidx;
        logic  want_next;
        elem_t prev;
        elem_t val;
    } probe_t;

    // input word to stored element: sign extend or truncate
    function automatic elem_t to_elem(logic signed [VAL_W-1:0] v);
        return ELEM_WIDTH'(v);
    endfunction

    // stored element to output word: sign extend or truncate
    function automatic logic signed [VAL_W-1:0] from_elem(elem_t e);
        return VAL_W'(e);
    endfunction

endpackage

[hdl/pol_if.sv]
// ----------------------------------------------------------------------------
// pol_if
// Valid/ready channels of the positional ordered list: the request channel
// and the response channel.
// ----------------------------------------------------------------------------

// request channel
interface pol_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

// response channel
interface pol_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [6:0]         found_position;
    logic [6:0]         length;

    modport source (output valid, status, result_value, found_position, length,
                    input ready);
    modport sink   (input valid, status, result_value, found_position, length,
                    output ready);
endinterface

[hdl/pol_cell.sv]
// ----------------------------------------------------------------------------
// pol_cell
// One list slot. Holds one element, shifts it to or from a neighbor on
// insert and delete, and passes the search probe on to the next cell.
// ----------------------------------------------------------------------------
module pol_cell
    import pol_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  idx_t       cell_idx,
    input  cnt_t       count,
    input  shift_cmd_t cmd,
    input  elem_t      left_elem,
    input  elem_t      right_elem,
    output elem_t      elem,
    input  probe_t     probe_in,
    output probe_t     probe_out
);

    elem_t  elem_reg;
    elem_t  elem_next;
    logic   probe_active_reg;
    probe_t probe_reg;
    probe_t probe_next;
    logic   in_range;

    assign in_range = cnt_t'(cell_idx) < count;

    // element shift
    always_comb
    begin
        elem_next = elem_reg;
        unique case (cmd.op)
            SH_INSERT:
            begin
                // slots below the insert point keep their element
                if (cell_idx > cmd.idx)
                    elem_next = left_elem;
                else if (cell_idx == cmd.idx)
                    elem_next = cmd.key;
            end
            SH_DELETE:
            begin
                if (cell_idx >= cmd.idx)
                    elem_next = right_elem;
            end
            default:
            begin
            end
        endcase
    end

    // probe update as it passes this slot
    always_comb
    begin
        probe_next      = probe_in;
        probe_next.prev = elem_reg;
        if (probe_in.active)
        begin
            unique case (probe_in.kind)
                REQ_GET, REQ_DELETE:
                begin
                    if (cell_idx == probe_in.target)
                        probe_next.val = elem_reg;
                end
                REQ_LOCATE, REQ_PRIOR, REQ_NEXT:
                begin
                    // slots that neither match nor follow a match pass the probe on
                    if (probe_in.found && probe_in.want_next)
                    begin
                        probe_next.val       = elem_reg;
                        probe_next.want_next = 1'b0;
                    end
                    else if (!probe_in.found && in_range && elem_reg == probe_in.key)
                    begin
                        probe_next.found     = 1'b1;
                        probe_next.fidx      = cell_idx;
                        probe_next.want_next = (probe_in.kind == REQ_NEXT);
                        if (probe_in.kind == REQ_PRIOR)
                            probe_next.val = probe_in.prev;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // element storage
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    // probe valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_active_reg <= 1'b0;
        else
            probe_active_reg <= probe_in.active;
    end

    // probe payload
    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
    end

    assign elem = elem_reg;

    always_comb
    begin
        probe_out        = probe_reg;
        probe_out.active = probe_active_reg;
    end

endmodule

[hdl/positional_ordered_list.sv]
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered list of up to CAPACITY signed words addressed by 1-based position.
//
// Usage:
//   Requests come in on the req channel (req_type, position, value) and one
//   response per request goes out on the rsp channel (status, result_value,
//   found_position, length). A transaction completes when valid and ready
//   are both high at a rising clock edge.
//   The list is a row of CAPACITY cells. Insert shifts the row when the
//   request is taken; its response, like every rejected request, is
//   registered in the cycle after the request transaction. Get, delete,
//   locate, prior and next send a probe down the cell row, one cell per
//   cycle, and their response is registered when it leaves the last cell;
//   delete shifts the row when the probe returns.
//   One request is in flight at a time: a new one is taken only after the
//   previous probe has walked the whole cell row and its response is built.
//   A new request is taken while the previous response sits in the output
//   register as long as that response is taken in the same cycle; while the
//   receiver stalls the response holds and no request is taken.
//   Reset (rst_n low, asynchronous) empties the list and drops any request
//   in flight; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module positional_ordered_list
    import pol_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pol_req_if.sink          req,
    pol_rsp_if.source        rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    cnt_t                      count_reg;
    cnt_t                      count_next;
    logic                      out_valid_reg;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [VAL_W-1:0]   rval_reg;
    logic signed [VAL_W-1:0]   rval_next;
    logic [FPOS_W-1:0]         fpos_reg;
    logic [FPOS_W-1:0]         fpos_next;

    logic                      accept;
    logic                      done_now;
    logic                      returned;
    logic                      pos_ok_ins;
    logic                      pos_ok_rd;
    logic [CMP_W-1:0]          pos_w;
    logic [CMP_W-1:0]          cnt_w;
    idx_t                      tgt;
    elem_t                     key;
    shift_cmd_t                cmd;
    probe_t                    launch;
    probe_t                    last;

    elem_t                     elems  [CAPACITY];
    probe_t                    probes [CAPACITY];
    logic [CAPACITY-1:0]       probe_act;

    // request decode
    assign req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;
    assign pos_w      = CMP_W'(req.position);
    assign cnt_w      = CMP_W'(count_reg);
    assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    assign pos_ok_rd  = (pos_w != '0) && (pos_w <= cnt_w);
    assign tgt        = IDX_W'(pos_w - CMP_W'(1));
    assign key        = to_elem(req.value);
    assign last       = probes[CAPACITY-1];
    assign returned   = (state_reg == ST_BUSY) && last.active;

    // control: launch, shift and response build
    always_comb
    begin
        cmd.op           = SH_HOLD;
        cmd.idx          = tgt;
        cmd.key          = key;
        launch.active    = 1'b0;
        launch.kind      = req_t'(req.req_type);
        launch.target    = tgt;
        launch.key       = key;
        launch.found     = 1'b0;
        launch.fidx      = '0;
        launch.want_next = 1'b0;
        launch.prev      = '0;
        launch.val       = '0;
        done_now         = 1'b0;
        status_next      = STAT_OK;
        rval_next        = '0;
        fpos_next        = '0;
        count_next       = count_reg;
        state_next       = state_reg;

        if (accept)
        begin
            unique case (req.req_type)
                REQ_INSERT:
                begin
                    done_now = 1'b1;
                    priority if (!pos_ok_ins)
                        status_next = STAT_BADPOS;
                    else if (count_reg == cnt_t'(CAPACITY))
                        status_next = STAT_FULL;
                    else
                    begin
                        cmd.op     = SH_INSERT;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                REQ_DELETE, REQ_GET:
                begin
                    if (!pos_ok_rd)
                    begin
                        done_now    = 1'b1;
                        status_next = STAT_BADPOS;
                    end
                    else
                    begin
                        launch.active = 1'b1;
                        state_next    = ST_BUSY;
                    end
                end
                REQ_LOCATE, REQ_PRIOR, REQ_NEXT:
                begin
                    launch.active = 1'b1;
                    state_next    = ST_BUSY;
                end
                default:
                begin
                    done_now    = 1'b1;
                    status_next = STAT_BADPOS;
                end
            endcase
        end
        else if (returned)
        begin
            done_now   = 1'b1;
            state_next = ST_IDLE;
            unique case (last.kind)
                REQ_GET:
                    rval_next = from_elem(last.val);
                REQ_DELETE:
                begin
                    rval_next  = from_elem(last.val);
                    cmd.op     = SH_DELETE;
                    cmd.idx    = last.target;
                    count_next = count_reg - cnt_t'(1);
                end
                default:
                begin
                    if (!last.found)
                        status_next = STAT_NOTFOUND;
                    else
                    begin
                        fpos_next = FPOS_W'(cnt_t'(last.fidx) + cnt_t'(1));
                        if (last.kind == REQ_PRIOR)
                        begin
                            if (last.fidx == '0)
                                status_next = STAT_NOEDGE;
                            else
                                rval_next = from_elem(last.val);
                        end
                        else if (last.kind == REQ_NEXT)
                        begin
                            if (cnt_t'(last.fidx) + cnt_t'(1) >= count_reg)
                                status_next = STAT_NOEDGE;
                            else
                                rval_next = from_elem(last.val);
                        end
                    end
                end
            endcase
        end
    end

    // state, length and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
            rval_reg      <= '0;
            fpos_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (done_now)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                rval_reg      <= rval_next;
                fpos_reg      <= fpos_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.result_value   = rval_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.length         = LEN_W'(count_reg);

    // cell row
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        pol_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (idx_t'(k)),
            .count      (count_reg),
            .cmd        (cmd),
            .left_elem  (elems[(k == 0) ? 0 : k - 1]),
            .right_elem (elems[(k == CAPACITY - 1) ? k : k + 1]),
            .elem       (elems[k]),
            .probe_in   ((k == 0) ? launch : probes[(k == 0) ? 0 : k - 1]),
            .probe_out  (probes[k])
        );
        assign probe_act[k] = probes[k].active;
    end

    // length never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("list length beyond capacity");

    // at most one probe walks the cell row
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_act))
        else $error("more than one probe in the cell row");

    // a probe only returns while a request is in flight
    a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        last.active |-> (state_reg == ST_BUSY))
        else $error("probe returned with no request in flight");

    // a new response never overwrites one that was not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done_now |-> (!out_valid_reg || rsp.ready))
        else $error("response register overwritten");

    // a valid insert into a list with room grows it by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_INSERT && pos_ok_ins
            && count_reg != cnt_t'(CAPACITY))
        |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("insert did not grow the list");

endmodule

[dv/tb_positional_ordered_list.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_ordered_list
// Self-checking bench for the positional ordered list. A short table of
// directed requests covers the empty list, bad positions, unused request
// codes and the first and last match. A long random part then fills, churns
// and drains the list, reaching the full list many times. Every response is
// compared field by field with its table row or a list model kept inside
// the bench. Both channels idle at random except in one steady stretch.
// ----------------------------------------------------------------------------
module tb_positional_ordered_list;
    import pol_pkg::*;

    // unused request codes, rejected by the block
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] V_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT     = 9;
    // far longer than a probe walk through the cell row plus the usual
    // receiver stalls, so this is many times the longest quiet gap
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] value;
        logic [6:0]         fpos;
        logic [6:0]         len;
    } outcome_t;

    typedef struct packed {
        logic [2:0]         rt;
        logic [7:0]         pos;
        logic signed [31:0] val;
        logic               typed;
        outcome_t           want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pol_req_if req_if ();
    pol_rsp_if rsp_if ();

    positional_ordered_list DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // list model
    elem_t    list_mem [CAPACITY];
    int       list_len;
    outcome_t pending_outcomes [$];

    int mismatches;
    int stall_cycles;
    bit steady;

    always #6 clk = ~clk;

    // apply one request to the list model and give its response
    function automatic outcome_t list_apply(logic [2:0] rt, logic [7:0] pos,
                                            logic signed [31:0] val);
        outcome_t o;
        elem_t    key;
        int       p;
        int       hit;
        o   = '0;
        o.status = STAT_OK;
        key = val;
        p   = pos;
        hit = -1;
        case (rt)
            REQ_INSERT:
            begin
                if (p < 1 || p > list_len + 1)
                    o.status = STAT_BADPOS;
                else if (list_len >= CAPACITY)
                    o.status = STAT_FULL;
                else
                begin
                    for (int k = list_len; k > p - 1; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = key;
                    list_len++;
                end
            end
            REQ_DELETE:
            begin
                if (p < 1 || p > list_len)
                    o.status = STAT_BADPOS;
                else
                begin
                    o.value = list_mem[p-1];
                    for (int k = p - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            REQ_GET:
            begin
                if (p < 1 || p > list_len)
                    o.status = STAT_BADPOS;
                else
                    o.value = list_mem[p-1];
            end
            REQ_LOCATE, REQ_PRIOR, REQ_NEXT:
            begin
                for (int k = 0; k < list_len; k++)
                    if (hit < 0 && list_mem[k] == key)
                        hit = k;
                if (hit < 0)
                    o.status = STAT_NOTFOUND;
                else
                begin
                    o.fpos = 7'(hit + 1);
                    if (rt == REQ_PRIOR)
                    begin
                        if (hit == 0)
                            o.status = STAT_NOEDGE;
                        else
                            o.value = list_mem[hit-1];
                    end
                    else if (rt == REQ_NEXT)
                    begin
                        if (hit + 1 >= list_len)
                            o.status = STAT_NOEDGE;
                        else
                            o.value = list_mem[hit+1];
                    end
                end
            end
            default:
                o.status = STAT_BADPOS;
        endcase
        o.len = 7'(list_len);
        return o;
    endfunction

    function automatic stim_row_t row(logic [2:0] rt, logic [7:0] pos,
                                      logic signed [31:0] val, logic typed,
                                      status_t st, logic signed [31:0] rv,
                                      logic [6:0] fp, logic [6:0] len);
        stim_row_t r;
        r.rt          = rt;
        r.pos         = pos;
        r.val         = val;
        r.typed       = typed;
        r.want.status = st;
        r.want.value  = rv;
        r.want.fpos   = fp;
        r.want.len    = len;
        return r;
    endfunction

    // drive one request transaction and record its expected response
    task automatic send_request(logic [2:0] rt, logic [7:0] pos,
                                logic signed [31:0] val, logic typed,
                                outcome_t want);
        outcome_t pred;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= rt;
        req_if.position <= pos;
        req_if.value    <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pred = list_apply(rt, pos, val);
        pending_outcomes.push_back(typed ? want : pred);
    endtask

    // stimulus
    initial
    begin
        stim_row_t          directed [$];
        logic [2:0]         rt;
        logic [7:0]         pos;
        logic signed [31:0] val;
        int                 ph;
        int                 r;
        int                 lim;
        int                 cuts [3][6];
        req_t               order [6];
        logic signed [31:0] pool [8];
        logic signed [31:0] edges [4];

        clk             = 1'b0;
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = '0;
        req_if.position = '0;
        req_if.value    = '0;
        rsp_if.ready    = 1'b0;
        list_len        = 0;
        mismatches      = 0;
        stall_cycles    = 0;
        steady          = 1'b0;
        foreach (list_mem[k])
            list_mem[k] = '0;

        // insert, delete, get, locate, prior, next weights per phase
        cuts  = '{'{70, 80, 88, 92, 95, 98},
                  '{30, 50, 65, 77, 87, 97},
                  '{15, 70, 80, 87, 93, 98}};
        order = '{REQ_INSERT, REQ_DELETE, REQ_GET, REQ_LOCATE, REQ_PRIOR, REQ_NEXT};
        pool  = '{32'sd1, 32'sd2, 32'sd3, -32'sd7, 32'sd100, -32'sd100, 32'sd42,
                  32'sh1234_5678};
        edges = '{V_MIN, V_MAX, 32'sd0, -32'sd1};

        // empty list, bad positions, extremes, first and last match
        directed.push_back(row(REQ_GET,    8'd1,   32'sd0, 1, STAT_BADPOS,   0, 0, 0));
        directed.push_back(row(REQ_DELETE, 8'd1,   32'sd0, 1, STAT_BADPOS,   0, 0, 0));
        directed.push_back(row(REQ_LOCATE, 8'd0,   32'sd0, 1, STAT_NOTFOUND, 0, 0, 0));
        directed.push_back(row(REQ_INSERT, 8'd0,   32'sd5, 1, STAT_BADPOS,   0, 0, 0));
        directed.push_back(row(REQ_INSERT, 8'd2,   32'sd5, 1, STAT_BADPOS,   0, 0, 0));
        directed.push_back(row(REQ_INSERT, 8'd1,   V_MIN,  1, STAT_OK,       0, 0, 1));
        directed.push_back(row(REQ_INSERT, 8'd2,   V_MAX,  1, STAT_OK,       0, 0, 2));
        directed.push_back(row(REQ_INSERT, 8'd1,   32'sd0, 1, STAT_OK,       0, 0, 3));
        directed.push_back(row(REQ_INSERT, 8'd4,  -32'sd1, 1, STAT_OK,       0, 0, 4));
        directed.push_back(row(REQ_INSERT, 8'd255, 32'sd9, 1, STAT_BADPOS,   0, 0, 4));
        directed.push_back(row(REQ_GET,    8'd2,   32'sd0, 1, STAT_OK,   V_MIN, 0, 4));
        directed.push_back(row(REQ_GET,    8'd4,   32'sd0, 1, STAT_OK,     -1, 0, 4));
        directed.push_back(row(REQ_GET,    8'd5,   32'sd0, 1, STAT_BADPOS,   0, 0, 4));
        directed.push_back(row(REQ_LOCATE, 8'd0,   V_MAX,  1, STAT_OK,       0, 3, 4));
        directed.push_back(row(REQ_PRIOR,  8'd0,   32'sd0, 1, STAT_NOEDGE,   0, 1, 4));
        directed.push_back(row(REQ_NEXT,   8'd0,  -32'sd1, 1, STAT_NOEDGE,   0, 4, 4));
        directed.push_back(row(REQ_PRIOR,  8'd0,   V_MAX,  1, STAT_OK,   V_MIN, 3, 4));
        directed.push_back(row(REQ_NEXT,   8'd0,   V_MIN,  1, STAT_OK,   V_MAX, 2, 4));
        // duplicate value, first match wins
        directed.push_back(row(REQ_INSERT, 8'd3,   32'sd0, 0, STAT_OK,       0, 0, 0));
        directed.push_back(row(REQ_NEXT,   8'd7,   32'sd0, 0, STAT_OK,       0, 0, 0));
        directed.push_back(row(REQ_PRIOR,  8'd0,  32'sd12345, 0, STAT_OK,    0, 0, 0));
        directed.push_back(row(REQ_UNUSED_6, 8'd1, 32'sd0, 1, STAT_BADPOS,   0, 0, 5));
        directed.push_back(row(REQ_UNUSED_7, 8'd1, V_MAX,  1, STAT_BADPOS,   0, 0, 5));
        directed.push_back(row(REQ_DELETE, 8'd1,   32'sd0, 0, STAT_OK,       0, 0, 0));
        directed.push_back(row(REQ_DELETE, 8'd4,   32'sd0, 0, STAT_OK,       0, 0, 0));
        directed.push_back(row(REQ_DELETE, 8'd0,   32'sd0, 1, STAT_BADPOS,   0, 0, 3));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].rt, directed[i].pos, directed[i].val,
                         directed[i].typed, directed[i].want);

        // random part: fill, churn and drain phases in turn
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 800 && n < 1100);
            ph = (n / 150) % 3;

            r  = $urandom_range(99);
            rt = ($urandom_range(1) != 0) ? REQ_UNUSED_7 : REQ_UNUSED_6;
            for (int k = 5; k >= 0; k--)
                if (r < cuts[ph][k])
                    rt = order[k];

            // mostly legal positions, some at the edges, some anywhere
            lim = (rt == REQ_INSERT) ? list_len + 1 : list_len;
            r   = $urandom_range(99);
            if (r < 80 && lim > 0)
                pos = 8'($urandom_range(lim, 1));
            else if (r < 90)
                case ($urandom_range(3))
                    0:       pos = 8'd0;
                    1:       pos = 8'(lim);
                    2:       pos = 8'(lim + 1);
                    default: pos = 8'(lim + 2);
                endcase
            else
                pos = 8'($urandom_range(255));

            // searches mostly look for a value that is in the list
            r = $urandom_range(99);
            if (rt != REQ_INSERT && list_len > 0 && r < 70)
                val = list_mem[$urandom_range(list_len - 1)];
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                    val = pool[$urandom_range(7)];
                else if (r < 50)
                    val = edges[$urandom_range(3)];
                else
                    val = $urandom;
            end

            send_request(rt, pos, val, 1'b0, '0);
        end
        steady = 1'b0;
        req_if.valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // response check, receiver stalls and idle cycle count
    always @(posedge clk)
    begin : rsp_monitor
        outcome_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: response with none expected: status %0d value %0d fpos %0d len %0d",
                                 $realtime, rsp_if.status, rsp_if.result_value,
                                 rsp_if.found_position, rsp_if.length);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (rsp_if.status !== want.status || rsp_if.result_value !== want.value ||
                        rsp_if.found_position !== want.fpos || rsp_if.length !== want.len)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected status %0d value %0d fpos %0d len %0d, got status %0d value %0d fpos %0d len %0d",
                                     $realtime, want.status, want.value, want.fpos, want.len,
                                     rsp_if.status, rsp_if.result_value,
                                     rsp_if.found_position, rsp_if.length);
                    end
                end
            end

            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;

            rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/pol_pkg.sv
hdl/pol_if.sv
hdl/pol_cell.sv
hdl/positional_ordered_list.sv
dv/tb_positional_ordered_list.sv
